>>> rtl/core/msh_pkg.sv
// Shared widths, register and mode codes, and inter-stage types for the
// distortion shaper pipeline. No dependencies.
package msh_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned OUT_W      = 18;
    localparam int unsigned AMOUNT_W   = 16;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 24;

    localparam int unsigned CUBE_W     = 48;
    localparam int unsigned TUBE_W     = 34;
    localparam int unsigned WPROD_W    = 40;
    localparam int unsigned DEN_W      = 39;
    localparam int unsigned NUM_SHIFT  = 14;
    localparam int unsigned REM_W      = WPROD_W + NUM_SHIFT;
    localparam int unsigned QUOT_W     = 16;
    localparam int unsigned RES_W      = 20;

    typedef logic [MODE_W-1:0] mode_t;
    typedef logic signed [RES_W-1:0] res_t;

    localparam mode_t MODE_SOFT = 2'd0;
    localparam mode_t MODE_TUBE = 2'd1;
    localparam mode_t MODE_WAVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_AMOUNT = 2'd1;

    localparam mode_t                MODE_RESET   = MODE_SOFT;
    localparam logic [AMOUNT_W-1:0]  AMOUNT_RESET = 16'd256;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct packed {
        mode_t                 mode;
        logic [AMOUNT_W-1:0]   amount;
    } cfg_t;

    typedef struct packed {
        logic                  neg;
        logic [WPROD_W-1:0]    prod;
        logic [DEN_W-1:0]      den;
    } wave_ops_t;

    typedef struct packed {
        mode_t                       mode;
        logic signed [SAMPLE_W-1:0]  x;
        logic signed [CUBE_W-1:0]    x3;
        logic signed [TUBE_W-1:0]    tn;
        wave_ops_t                   ops;
    } front_t;

    typedef struct packed {
        mode_t      mode;
        res_t       alt;
        wave_ops_t  ops;
    } poly_t;

    typedef struct packed {
        mode_t               mode;
        res_t                alt;
        logic                neg;
        logic [REM_W-1:0]    rem;
        logic [DEN_W-1:0]    den;
        logic [QUOT_W-1:0]   q;
    } divs_t;

endpackage

>>> rtl/core/multimode_distortion_shaper_unit.sv
// Multimode distortion shaper: top level with the configuration registers and
// the four pipeline sections. Uses msh_pkg, msh_front, msh_poly, msh_div, msh_out.
//
// Usage:
//   s_ channel carries one signed Q1.15 sample per transfer in s_tdata[15:0].
//   m_ channel returns one shaped signed Q3.14 sample per transfer in
//   m_tdata[17:0]; the upper bits read zero.
//   cfg_wr_en/cfg_wr_index/cfg_wr_data write shape_mode (index 0, 0 soft clip,
//   1 tube, 2 waveshaper, 3 gives zero) and shape_amount (index 1, Q8.8).
//   Write them only while no sample is in flight.
// From an input transfer to its output transfer a sample passes three
// multiplier stages, four stages for the polynomial curves, sixteen divider
// stages (one quotient bit each) and two output stages.
// Throughput is one sample per cycle while m_tready is high. Every stage has
// its own valid bit, so when m_tready is low the stages behind the result keep
// filling until the pipeline is full, and only then s_tready falls; nothing is
// lost or repeated. Synchronous active-low reset empties the pipeline and sets
// shape_mode to 0 and shape_amount to 1.0; no clearing pass is needed.
module multimode_distortion_shaper_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [msh_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [msh_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [msh_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] sample_in
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [msh_pkg::M_TDATA_W-1:0]      m_tdata    // [17:0] sample_out
);

    msh_pkg::mode_t                  shape_mode_reg;
    logic [msh_pkg::AMOUNT_W-1:0]    shape_amount_reg;
    msh_pkg::cfg_t                   cfg;

    msh_pkg::front_t                 front_data;
    msh_pkg::poly_t                  poly_data;
    msh_pkg::divs_t                  div_data;
    logic                            front_valid, front_ready;
    logic                            poly_valid, poly_ready;
    logic                            div_valid, div_ready;
    logic signed [msh_pkg::OUT_W-1:0] sample_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_mode_reg   <= msh_pkg::MODE_RESET;
            shape_amount_reg <= msh_pkg::AMOUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                msh_pkg::REG_SHAPE_MODE:   shape_mode_reg   <= cfg_wr_data[msh_pkg::MODE_W-1:0];
                msh_pkg::REG_SHAPE_AMOUNT: shape_amount_reg <= cfg_wr_data[msh_pkg::AMOUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.mode   = shape_mode_reg;
    assign cfg.amount = shape_amount_reg;

    msh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample ($signed(s_tdata[msh_pkg::SAMPLE_W-1:0])),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    msh_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_data  (poly_data)
    );

    msh_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .in_data   (poly_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    msh_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_data    (div_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (sample_out)
    );

    assign m_tdata = {{(msh_pkg::M_TDATA_W - msh_pkg::OUT_W){1'b0}}, sample_out};

endmodule

>>> rtl/core/msh_front.sv
// Front end of the shaper: input register and the multiplier stages that form
// x^2, x^3, the tube polynomial and the waveshaper operands. Uses msh_pkg.
module msh_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  msh_pkg::cfg_t                    cfg,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [msh_pkg::SAMPLE_W-1:0] in_sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output msh_pkg::front_t                  out_data
);

    localparam int NST = 3;

    typedef struct packed {
        msh_pkg::mode_t                        mode;
        logic signed [msh_pkg::SAMPLE_W-1:0]   x;
        logic [msh_pkg::SAMPLE_W-1:0]          m;
        logic signed [msh_pkg::AMOUNT_W:0]     amn;
        logic [msh_pkg::AMOUNT_W+6:0]          a7;
    } st1_t;

    typedef struct packed {
        msh_pkg::mode_t                        mode;
        logic signed [msh_pkg::SAMPLE_W-1:0]   x;
        logic [msh_pkg::SAMPLE_W-1:0]          m;
        logic [30:0]                           x2;
        logic [30:0]                           m2;
        logic [23:0]                           ma;
        logic signed [33:0]                    lin;
    } st2_t;

    st1_t             st1_reg, st1_next;
    st2_t             st2_reg, st2_next;
    msh_pkg::front_t  st3_reg, st3_next;

    logic [NST-1:0]   valid_reg, valid_next, valid_in, adv;

    logic [msh_pkg::SAMPLE_W-1:0] raw;
    logic signed [31:0]           sq_x;
    logic [31:0]                  sq_m;
    logic signed [33:0]           lin;
    logic signed [47:0]           cube;
    logic [39:0]                  wprod;
    logic signed [40:0]           den_full;

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            adv[k] = out_ready || ((valid_reg | NST'((1 << k) - 1)) != '1);
        end
        valid_in   = {valid_reg[NST-2:0], in_valid};
        valid_next = (adv & valid_in) | (~adv & valid_reg);
    end

    always_comb begin
        raw           = in_sample;
        st1_next.mode = cfg.mode;
        st1_next.x    = in_sample;
        st1_next.m    = raw[msh_pkg::SAMPLE_W-1] ? (~raw + 16'd1) : raw;
        st1_next.amn  = $signed({1'b0, cfg.amount}) - 17'sd256;
        st1_next.a7   = {cfg.amount, 7'b0};
    end

    always_comb begin
        sq_x          = st1_reg.x * st1_reg.x;
        sq_m          = st1_reg.m * st1_reg.m;
        lin           = st1_reg.amn * $signed({1'b0, st1_reg.m});
        st2_next.mode = st1_reg.mode;
        st2_next.x    = st1_reg.x;
        st2_next.m    = st1_reg.m;
        st2_next.x2   = sq_x[30:0];
        st2_next.m2   = sq_m[30:0];
        st2_next.ma   = {8'b0, st1_reg.m} + {1'b0, st1_reg.a7};
        st2_next.lin  = lin;
    end

    always_comb begin
        cube     = $signed({1'b0, st2_reg.x2}) * st2_reg.x;
        wprod    = st2_reg.m * st2_reg.ma;
        den_full = $signed({10'b0, st2_reg.m2})
                 + $signed({st2_reg.lin, 7'b0})
                 + 41'sd1073741824;
        st3_next.mode     = st2_reg.mode;
        st3_next.x        = st2_reg.x;
        st3_next.x3       = cube;
        st3_next.tn       = $signed({3'b0, st2_reg.x2})
                          + $signed({{3{st2_reg.x[15]}}, st2_reg.x, 15'b0});
        st3_next.ops.neg  = st2_reg.x[msh_pkg::SAMPLE_W-1];
        st3_next.ops.prod = wprod;
        st3_next.ops.den  = den_full[msh_pkg::DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_reg <= st1_next;
        end
        if (adv[1]) begin
            st2_reg <= st2_next;
        end
        if (adv[2]) begin
            st3_reg <= st3_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = st3_reg;

endmodule

>>> rtl/core/msh_poly.sv
// Polynomial curves: finishes the soft clip (rounded division by three) and
// the tube curve, and carries the waveshaper operands along. Uses msh_pkg.
module msh_poly (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  msh_pkg::front_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output msh_pkg::poly_t   out_data
);

    localparam int NST = 4;

    localparam logic [33:0]     TUBE_BIAS       = 34'd32768;
    localparam logic [49:0]     SOFT_BIAS       = 50'd3221225472;
    localparam logic [14:0]     RECIP3          = 15'd21845;
    localparam msh_pkg::res_t   SOFT_NEG_LIMIT  = -20'sd10923;

    typedef struct packed {
        msh_pkg::mode_t                        mode;
        logic signed [msh_pkg::SAMPLE_W-1:0]   x;
        logic signed [49:0]                    sn;
        logic                                  tneg;
        logic [33:0]                           tt;
        msh_pkg::wave_ops_t                    ops;
    } p1_t;

    typedef struct packed {
        msh_pkg::mode_t                        mode;
        logic signed [msh_pkg::SAMPLE_W-1:0]   x;
        logic                                  sneg;
        logic [16:0]                           v;
        msh_pkg::res_t                         tres;
        msh_pkg::wave_ops_t                    ops;
    } p2_t;

    typedef struct packed {
        msh_pkg::mode_t                        mode;
        logic signed [msh_pkg::SAMPLE_W-1:0]   x;
        logic                                  sneg;
        logic [16:0]                           v;
        logic [15:0]                           est;
        msh_pkg::res_t                         tres;
        msh_pkg::wave_ops_t                    ops;
    } p3_t;

    p1_t             p1_reg, p1_next;
    p2_t             p2_reg, p2_next;
    p3_t             p3_reg, p3_next;
    msh_pkg::poly_t  p4_reg, p4_next;

    logic [NST-1:0]  valid_reg, valid_next, valid_in, adv;

    logic [33:0]     tn_u;
    logic [49:0]     sn_u, st;
    logic [17:0]     tq;
    msh_pkg::res_t   tmag, smag, sres;
    logic [31:0]     prod;
    logic [17:0]     three_est, rest;
    logic [16:0]     sq;

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            adv[k] = out_ready || ((valid_reg | NST'((1 << k) - 1)) != '1);
        end
        valid_in   = {valid_reg[NST-2:0], in_valid};
        valid_next = (adv & valid_in) | (~adv & valid_reg);
    end

    always_comb begin
        tn_u         = in_data.tn;
        p1_next.mode = in_data.mode;
        p1_next.x    = in_data.x;
        p1_next.sn   = $signed({{3{in_data.x[15]}}, in_data.x, 31'b0})
                     + $signed({{4{in_data.x[15]}}, in_data.x, 30'b0})
                     - $signed({{2{in_data.x3[47]}}, in_data.x3});
        p1_next.tneg = in_data.tn[msh_pkg::TUBE_W-1];
        p1_next.tt   = in_data.tn[msh_pkg::TUBE_W-1] ? (TUBE_BIAS - tn_u) : (tn_u + TUBE_BIAS);
        p1_next.ops  = in_data.ops;
    end

    always_comb begin
        sn_u         = p1_reg.sn;
        st           = p1_reg.sn[49] ? (SOFT_BIAS - sn_u) : (sn_u + SOFT_BIAS);
        tq           = p1_reg.tt[33:16];
        tmag         = $signed({2'b0, tq});
        p2_next.mode = p1_reg.mode;
        p2_next.x    = p1_reg.x;
        p2_next.sneg = p1_reg.sn[49];
        p2_next.v    = st[47:31];
        p2_next.tres = p1_reg.tneg ? -tmag : tmag;
        p2_next.ops  = p1_reg.ops;
    end

    always_comb begin
        prod         = p2_reg.v * RECIP3;
        p3_next.mode = p2_reg.mode;
        p3_next.x    = p2_reg.x;
        p3_next.sneg = p2_reg.sneg;
        p3_next.v    = p2_reg.v;
        p3_next.est  = prod[31:16];
        p3_next.tres = p2_reg.tres;
        p3_next.ops  = p2_reg.ops;
    end

    always_comb begin
        three_est = {2'b0, p3_reg.est} + {1'b0, p3_reg.est, 1'b0};
        rest      = {1'b0, p3_reg.v} - three_est;
        sq        = (rest >= 18'd3) ? ({1'b0, p3_reg.est} + 17'd1) : {1'b0, p3_reg.est};
        smag      = $signed({3'b0, sq});
        if (p3_reg.x == msh_pkg::SAMPLE_MIN) begin
            sres = SOFT_NEG_LIMIT;
        end else begin
            sres = p3_reg.sneg ? -smag : smag;
        end
        p4_next.mode = p3_reg.mode;
        p4_next.ops  = p3_reg.ops;
        case (p3_reg.mode)
            msh_pkg::MODE_SOFT: p4_next.alt = sres;
            msh_pkg::MODE_TUBE: p4_next.alt = p3_reg.tres;
            default:            p4_next.alt = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            p1_reg <= p1_next;
        end
        if (adv[1]) begin
            p2_reg <= p2_next;
        end
        if (adv[2]) begin
            p3_reg <= p3_next;
        end
        if (adv[3]) begin
            p4_reg <= p4_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = p4_reg;

endmodule

>>> rtl/core/msh_div.sv
// Pipelined restoring divider for the waveshaper quotient: one quotient bit
// per stage, with the polynomial result riding alongside. Uses msh_pkg.
module msh_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  msh_pkg::poly_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output msh_pkg::divs_t  out_data
);

    localparam int NST = msh_pkg::QUOT_W;

    msh_pkg::divs_t stage_reg  [NST];
    msh_pkg::divs_t stage_in   [NST];
    msh_pkg::divs_t stage_next [NST];
    logic [msh_pkg::REM_W:0] dsh [NST];

    logic [NST-1:0] valid_reg, valid_next, valid_in, adv;

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            adv[k] = out_ready || ((valid_reg | NST'((1 << k) - 1)) != '1);
        end
        valid_in   = {valid_reg[NST-2:0], in_valid};
        valid_next = (adv & valid_in) | (~adv & valid_reg);
    end

    always_comb begin
        stage_in[0].mode = in_data.mode;
        stage_in[0].alt  = in_data.alt;
        stage_in[0].neg  = in_data.ops.neg;
        stage_in[0].rem  = {in_data.ops.prod, {msh_pkg::NUM_SHIFT{1'b0}}};
        stage_in[0].den  = in_data.ops.den;
        stage_in[0].q    = '0;
        for (int k = 1; k < NST; k++) begin
            stage_in[k] = stage_reg[k-1];
        end
        for (int k = 0; k < NST; k++) begin
            stage_next[k] = stage_in[k];
            dsh[k] = {{(msh_pkg::REM_W + 1 - msh_pkg::DEN_W){1'b0}}, stage_in[k].den}
                     << (NST - 1 - k);
            if ({1'b0, stage_in[k].rem} >= dsh[k]) begin
                stage_next[k].rem          = stage_in[k].rem - dsh[k][msh_pkg::REM_W-1:0];
                stage_next[k].q[NST-1-k]   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NST; k++) begin
            if (adv[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = stage_reg[NST-1];

endmodule

>>> rtl/core/msh_out.sv
// Output end: rounds and signs the waveshaper quotient, selects the curve by
// mode, saturates to Q3.14 and holds the result register. Uses msh_pkg.
module msh_out (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  msh_pkg::divs_t                       in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [msh_pkg::OUT_W-1:0]     out_sample
);

    localparam int NST = 2;

    localparam msh_pkg::res_t OUT_MAX = 20'sd131071;
    localparam msh_pkg::res_t OUT_MIN = -20'sd131072;

    typedef struct packed {
        msh_pkg::mode_t  mode;
        msh_pkg::res_t   alt;
        msh_pkg::res_t   wres;
    } o1_t;

    o1_t                                o1_reg, o1_next;
    logic signed [msh_pkg::OUT_W-1:0]   o2_reg, o2_next;

    logic [NST-1:0]             valid_reg, valid_next, valid_in, adv;
    logic                       rnd;
    logic [msh_pkg::QUOT_W:0]   wq;
    msh_pkg::res_t              wmag, sel;

    function automatic logic signed [msh_pkg::OUT_W-1:0] saturate(msh_pkg::res_t v);
        msh_pkg::res_t c;
        if (v > OUT_MAX) begin
            c = OUT_MAX;
        end else if (v < OUT_MIN) begin
            c = OUT_MIN;
        end else begin
            c = v;
        end
        return c[msh_pkg::OUT_W-1:0];
    endfunction

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            adv[k] = out_ready || ((valid_reg | NST'((1 << k) - 1)) != '1);
        end
        valid_in   = {valid_reg[NST-2:0], in_valid};
        valid_next = (adv & valid_in) | (~adv & valid_reg);
    end

    always_comb begin
        rnd  = {in_data.rem[msh_pkg::DEN_W-1:0], 1'b0} >= {1'b0, in_data.den};
        wq   = {1'b0, in_data.q} + {{msh_pkg::QUOT_W{1'b0}}, rnd};
        wmag = $signed({{(msh_pkg::RES_W - msh_pkg::QUOT_W - 1){1'b0}}, wq});
        o1_next.mode = in_data.mode;
        o1_next.alt  = in_data.alt;
        o1_next.wres = in_data.neg ? -wmag : wmag;
    end

    always_comb begin
        sel     = (o1_reg.mode == msh_pkg::MODE_WAVE) ? o1_reg.wres : o1_reg.alt;
        o2_next = saturate(sel);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            o1_reg <= o1_next;
        end
        if (adv[1]) begin
            o2_reg <= o2_next;
        end
    end

    assign in_ready   = adv[0];
    assign out_valid  = valid_reg[NST-1];
    assign out_sample = o2_reg;

endmodule
